// File: hdl/lra_pkg.sv
`default_nettype none

package lra_pkg;

    // Coordinate width of every endpoint and pixel field.
    localparam int COORD_BITS = 12;

    // Width of the signed error terms.
    localparam int TERM_BITS = COORD_BITS + 3;

    // Command codes carried in the mode field.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // One command transfer.
    typedef struct packed {
        logic                  mode;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
    } lra_cmd_t;

    // One pixel transfer.
    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  pixel_valid;
        logic                  last_pixel;
    } lra_pix_t;

    // Initial line state worked out from a load command.
    typedef struct packed {
        logic                        zero_len;
        logic                        steep;
        logic                        minor_desc;
        logic [COORD_BITS-1:0]       major_pos;
        logic [COORD_BITS-1:0]       minor_pos;
        logic [COORD_BITS-1:0]       major_stop;
        logic signed [TERM_BITS-1:0] decision;
        logic signed [TERM_BITS-1:0] straight_inc;
        logic signed [TERM_BITS-1:0] diagonal_inc;
    } lra_setup_t;

endpackage

`default_nettype wire

// File: hdl/line_rasterizer_all_octants_core.sv
`default_nettype none
// Bresenham line rasterizer covering all eight octants.
// Command channel (cmd_valid, cmd_stall, cmd): mode LOAD carries two
// endpoints, sets up a new line and returns its first pixel; mode STEP
// returns the next pixel of the current line. A load abandons any line
// in progress. A zero-length line, or a step with no line active, returns
// a result with pixel_valid low and last_pixel high.
// Pixel channel (pix_valid, pix_stall, pix): exactly one result per command,
// in command order; last_pixel marks the line's end point.
// A command passes from the input register through the setup/step logic
// into the result register. Throughput is one command per cycle while
// the receiver does not stall, set by the update of the line state.
// When the receiver stalls, the result register holds its pixel and the
// input register fills, after which cmd_stall rises.
// Reset clears both valid flags and leaves no line active.
module line_rasterizer_all_octants_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire lra_pkg::lra_cmd_t cmd,
    output logic                   pix_valid,
    input  wire logic              pix_stall,
    output lra_pkg::lra_pix_t      pix
);
    import lra_pkg::*;

    logic       engine_ready;
    logic       held_valid;
    lra_cmd_t   held_cmd;
    lra_setup_t setup;

    lra_in_reg u_in_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .engine_ready (engine_ready),
        .held_valid   (held_valid),
        .held_cmd     (held_cmd)
    );

    lra_setup u_setup (
        .cmd   (held_cmd),
        .setup (setup)
    );

    lra_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .held_valid   (held_valid),
        .held_cmd     (held_cmd),
        .setup        (setup),
        .engine_ready (engine_ready),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .pix          (pix)
    );

endmodule

`default_nettype wire

// File: hdl/lra_in_reg.sv
`default_nettype none

module lra_in_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire lra_pkg::lra_cmd_t cmd,
    input  wire logic              engine_ready,
    output logic                   held_valid,
    output lra_pkg::lra_cmd_t      held_cmd
);
    import lra_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    lra_cmd_t cmd_reg;

    // The register holds its command until the engine takes it.
    assign cmd_stall  = valid_reg && !engine_ready;
    assign valid_next = cmd_stall ? valid_reg : cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload is captured on every accepted transfer.
    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            cmd_reg <= cmd;
        end
    end

    assign held_valid = valid_reg;
    assign held_cmd   = cmd_reg;

endmodule

`default_nettype wire

// File: hdl/lra_setup.sv
`default_nettype none

module lra_setup (
    input  wire lra_pkg::lra_cmd_t cmd,
    output lra_pkg::lra_setup_t    setup
);
    import lra_pkg::*;

    logic [COORD_BITS-1:0]       adx;
    logic [COORD_BITS-1:0]       ady;
    logic                        steep;
    logic [COORD_BITS-1:0]       ma0;
    logic [COORD_BITS-1:0]       mi0;
    logic [COORD_BITS-1:0]       ma1;
    logic [COORD_BITS-1:0]       mi1;
    logic [COORD_BITS-1:0]       lo_major;
    logic [COORD_BITS-1:0]       lo_minor;
    logic [COORD_BITS-1:0]       hi_major;
    logic [COORD_BITS-1:0]       hi_minor;
    logic [COORD_BITS-1:0]       dmaj;
    logic [COORD_BITS-1:0]       dmin;
    logic                        desc;
    logic signed [TERM_BITS-1:0] dmaj_s;
    logic signed [TERM_BITS-1:0] dmin2_s;

    always_comb
    begin
        // Absolute deltas pick the major axis.
        adx = (cmd.x_end >= cmd.x_start) ? (cmd.x_end - cmd.x_start)
                                         : (cmd.x_start - cmd.x_end);
        ady = (cmd.y_end >= cmd.y_start) ? (cmd.y_end - cmd.y_start)
                                         : (cmd.y_start - cmd.y_end);
        steep = (ady > adx);

        if (steep)
        begin
            ma0 = cmd.y_start;
            mi0 = cmd.x_start;
            ma1 = cmd.y_end;
            mi1 = cmd.x_end;
        end
        else
        begin
            ma0 = cmd.x_start;
            mi0 = cmd.y_start;
            ma1 = cmd.x_end;
            mi1 = cmd.y_end;
        end

        // Order the endpoints so that the major coordinate rises.
        if (ma1 < ma0)
        begin
            lo_major = ma1;
            lo_minor = mi1;
            hi_major = ma0;
            hi_minor = mi0;
        end
        else
        begin
            lo_major = ma0;
            lo_minor = mi0;
            hi_major = ma1;
            hi_minor = mi1;
        end

        dmaj = hi_major - lo_major;
        desc = (hi_minor < lo_minor);
        dmin = desc ? (lo_minor - hi_minor) : (hi_minor - lo_minor);

        // Error terms: 2*dmin, 2*(dmin-dmaj) and 2*dmin-dmaj.
        dmaj_s  = signed'({{(TERM_BITS-COORD_BITS){1'b0}}, dmaj});
        dmin2_s = signed'({{(TERM_BITS-COORD_BITS-1){1'b0}}, dmin, 1'b0});

        setup.zero_len     = (cmd.x_start == cmd.x_end) && (cmd.y_start == cmd.y_end);
        setup.steep        = steep;
        setup.minor_desc   = desc;
        setup.major_pos    = lo_major;
        setup.minor_pos    = lo_minor;
        setup.major_stop   = hi_major;
        setup.straight_inc = dmin2_s;
        setup.diagonal_inc = dmin2_s - (dmaj_s <<< 1);
        setup.decision     = dmin2_s - dmaj_s;
    end

endmodule

`default_nettype wire

// File: hdl/lra_engine.sv
`default_nettype none

module lra_engine (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                held_valid,
    input  wire lra_pkg::lra_cmd_t   held_cmd,
    input  wire lra_pkg::lra_setup_t setup,
    output logic                     engine_ready,
    output logic                     pix_valid,
    input  wire logic                pix_stall,
    output lra_pkg::lra_pix_t        pix
);
    import lra_pkg::*;

    logic                        take;

    // Line state.
    logic [COORD_BITS-1:0]       major_reg;
    logic [COORD_BITS-1:0]       major_next;
    logic [COORD_BITS-1:0]       minor_reg;
    logic [COORD_BITS-1:0]       minor_next;
    logic [COORD_BITS-1:0]       stop_reg;
    logic [COORD_BITS-1:0]       stop_next;
    logic signed [TERM_BITS-1:0] dec_reg;
    logic signed [TERM_BITS-1:0] dec_next;
    logic signed [TERM_BITS-1:0] str_reg;
    logic signed [TERM_BITS-1:0] str_next;
    logic signed [TERM_BITS-1:0] diag_reg;
    logic signed [TERM_BITS-1:0] diag_next;
    logic                        steep_reg;
    logic                        steep_next;
    logic                        desc_reg;
    logic                        desc_next;
    logic                        active_reg;
    logic                        active_next;

    // Result register.
    logic                        res_valid_reg;
    logic                        res_valid_next;
    lra_pix_t                    res_reg;
    lra_pix_t                    res_next;

    assign engine_ready = !res_valid_reg || !pix_stall;
    assign take         = held_valid && engine_ready;

    // Load or step: next line state and the pixel it produces.
    always_comb
    begin
        major_next  = major_reg;
        minor_next  = minor_reg;
        stop_next   = stop_reg;
        dec_next    = dec_reg;
        str_next    = str_reg;
        diag_next   = diag_reg;
        steep_next  = steep_reg;
        desc_next   = desc_reg;
        active_next = active_reg;
        res_next    = '{pixel_x: '0, pixel_y: '0, pixel_valid: 1'b0, last_pixel: 1'b1};

        if (held_cmd.mode == MODE_LOAD)
        begin
            active_next = 1'b0;
            if (!setup.zero_len)
            begin
                major_next  = setup.major_pos;
                minor_next  = setup.minor_pos;
                stop_next   = setup.major_stop;
                dec_next    = setup.decision;
                str_next    = setup.straight_inc;
                diag_next   = setup.diagonal_inc;
                steep_next  = setup.steep;
                desc_next   = setup.minor_desc;
                active_next = 1'b1;
            end
        end
        else if (!active_reg || (major_reg >= stop_reg))
        begin
            active_next = 1'b0;
        end
        else
        begin
            // Bresenham step: straight when the decision term is not positive.
            major_next = major_reg + COORD_BITS'(1);
            if (dec_reg[TERM_BITS-1] || (dec_reg == '0))
            begin
                dec_next = dec_reg + str_reg;
            end
            else
            begin
                dec_next   = dec_reg + diag_reg;
                minor_next = desc_reg ? (minor_reg - COORD_BITS'(1))
                                      : (minor_reg + COORD_BITS'(1));
            end
        end

        // Any line still active after the update emits its current pixel.
        if (active_next)
        begin
            res_next.pixel_x     = steep_next ? minor_next : major_next;
            res_next.pixel_y     = steep_next ? major_next : minor_next;
            res_next.pixel_valid = 1'b1;
            res_next.last_pixel  = (major_next == stop_next);
            if (major_next == stop_next)
            begin
                active_next = 1'b0;
            end
        end
    end

    assign res_valid_next = take ? 1'b1 : (res_valid_reg && pix_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_reg     <= '0;
            minor_reg     <= '0;
            stop_reg      <= '0;
            dec_reg       <= '0;
            str_reg       <= '0;
            diag_reg      <= '0;
            steep_reg     <= 1'b0;
            desc_reg      <= 1'b0;
            active_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                major_reg  <= major_next;
                minor_reg  <= minor_next;
                stop_reg   <= stop_next;
                dec_reg    <= dec_next;
                str_reg    <= str_next;
                diag_reg   <= diag_next;
                steep_reg  <= steep_next;
                desc_reg   <= desc_next;
                active_reg <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign pix_valid = res_valid_reg;
    assign pix       = res_reg;

endmodule

`default_nettype wire

// File: tb/line_rasterizer_all_octants_core_tb.sv
module line_rasterizer_all_octants_core_tb;

    import lra_pkg::*;

    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int RANDOM_ITEMS = 1350;
    localparam int DRAIN_EVERY  = 250;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 8;

    // One row of the directed stimulus table.
    typedef struct {
        lra_cmd_t cmd;
        bit       typed;
        lra_pix_t want;
    } drill_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    lra_cmd_t cmd_word = '0;
    logic     pix_valid;
    logic     pix_stall = 1'b0;
    lra_pix_t pix;

    // Line state of the predictor.
    logic [COORD_BITS-1:0]       maj_pos = '0;
    logic [COORD_BITS-1:0]       min_pos = '0;
    logic [COORD_BITS-1:0]       maj_stop = '0;
    logic signed [TERM_BITS-1:0] err_term = '0;
    logic signed [TERM_BITS-1:0] err_straight = '0;
    logic signed [TERM_BITS-1:0] err_diag = '0;
    logic                        is_steep = 1'b0;
    logic                        min_down = 1'b0;
    logic                        drawing = 1'b0;

    lra_pix_t   pending_pix[$];
    lra_pix_t   want_pix;
    drill_row_t drill_rows[$];

    bit calm = 1'b0;
    int errors = 0;
    int cycle_count = 0;
    int stall_left = 0;
    int loads_sent = 0;
    int steps_sent = 0;
    int results_seen = 0;
    int pixels_seen = 0;
    int ends_seen = 0;

    line_rasterizer_all_octants_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd_word),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix)
    );

    // Free-running clock with a period of two time units.
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Reset is held at the start of the run only. The falling
    // edge is scheduled after every process has started waiting on it.
    initial
    begin
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // The run is cut short if it goes on far longer than any correct run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d pixels still pending", $time, pending_pix.size());
            $display("line_rasterizer_all_octants_core_tb NOT OK");
            $finish;
        end
    end

    // Idle length: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (calm || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic int rand_coord();
        return $urandom_range(COORD_MAX, 0);
    endfunction

    // A coordinate within the given distance of c, kept on the screen.
    function automatic int near_coord(int c, int span);
        int lo;
        int hi;
        lo = (c - span < 0) ? 0 : c - span;
        hi = (c + span > COORD_MAX) ? COORD_MAX : c + span;
        return $urandom_range(hi, lo);
    endfunction

    function automatic lra_cmd_t make_cmd(logic m, int xs, int ys, int xe, int ye);
        lra_cmd_t c;
        c.mode    = m;
        c.x_start = xs[COORD_BITS-1:0];
        c.y_start = ys[COORD_BITS-1:0];
        c.x_end   = xe[COORD_BITS-1:0];
        c.y_end   = ye[COORD_BITS-1:0];
        return c;
    endfunction

    // Works out the pixel that a command yields and advances the line state.
    function automatic lra_pix_t predict_pixel(lra_cmd_t c);
        int xs;
        int ys;
        int xe;
        int ye;
        int adx;
        int ady;
        int ma0;
        int mi0;
        int ma1;
        int mi1;
        int dmin;
        int swap;
        lra_pix_t p;
        p = '0;
        p.last_pixel = 1'b1;
        if (c.mode == MODE_LOAD)
        begin
            xs = int'(c.x_start);
            ys = int'(c.y_start);
            xe = int'(c.x_end);
            ye = int'(c.y_end);
            drawing = 1'b0;
            adx = (xe > xs) ? xe - xs : xs - xe;
            ady = (ye > ys) ? ye - ys : ys - ye;
            // A line of zero length draws nothing.
            if (adx == 0 && ady == 0)
                return p;
            is_steep = (ady > adx);
            if (is_steep)
            begin
                ma0 = ys; mi0 = xs; ma1 = ye; mi1 = xe;
            end
            else
            begin
                ma0 = xs; mi0 = ys; ma1 = xe; mi1 = ye;
            end
            // Walk the major axis upward.
            if (ma1 < ma0)
            begin
                swap = ma0; ma0 = ma1; ma1 = swap;
                swap = mi0; mi0 = mi1; mi1 = swap;
            end
            dmin = mi1 - mi0;
            min_down = (dmin < 0);
            if (dmin < 0)
                dmin = -dmin;
            maj_pos      = ma0[COORD_BITS-1:0];
            min_pos      = mi0[COORD_BITS-1:0];
            maj_stop     = ma1[COORD_BITS-1:0];
            err_straight = TERM_BITS'(2 * dmin);
            err_diag     = TERM_BITS'(2 * (dmin - (ma1 - ma0)));
            err_term     = TERM_BITS'(2 * dmin - (ma1 - ma0));
            drawing      = 1'b1;
        end
        else
        begin
            // A step with no line left to draw changes nothing.
            if (!drawing || maj_pos >= maj_stop)
            begin
                drawing = 1'b0;
                return p;
            end
            maj_pos = maj_pos + 1'b1;
            if (err_term <= 0)
                err_term = err_term + err_straight;
            else
            begin
                err_term = err_term + err_diag;
                min_pos = min_down ? min_pos - 1'b1 : min_pos + 1'b1;
            end
        end
        p.pixel_x     = is_steep ? min_pos : maj_pos;
        p.pixel_y     = is_steep ? maj_pos : min_pos;
        p.pixel_valid = 1'b1;
        p.last_pixel  = (maj_pos == maj_stop);
        if (p.last_pixel)
            drawing = 1'b0;
        return p;
    endfunction

    task automatic add_row(logic m, int xs, int ys, int xe, int ye, bit typed,
                           int px, int py, bit pv, bit lp);
        drill_row_t r;
        r.cmd               = make_cmd(m, xs, ys, xe, ye);
        r.typed             = typed;
        r.want.pixel_x      = px[COORD_BITS-1:0];
        r.want.pixel_y      = py[COORD_BITS-1:0];
        r.want.pixel_valid  = pv;
        r.want.last_pixel   = lp;
        drill_rows.push_back(r);
    endtask

    // Holds the command until it is taken, then queues its expected pixel.
    task automatic send_cmd(lra_cmd_t c, bit typed, lra_pix_t want);
        lra_pix_t p;
        int gap;
        cmd_word  <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        p = predict_pixel(c);
        pending_pix.push_back(typed ? want : p);
        if (c.mode == MODE_LOAD)
            loads_sent++;
        else
            steps_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_step();
        send_cmd(make_cmd(MODE_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord()),
                 1'b0, '0);
    endtask

    // The sender holds off until every pending pixel has come back.
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_pix.size() != 0);
    endtask

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Pixel side: check every transfer, then choose the next stall.
    always @(posedge clk)
    begin
        if (rst_n && pix_valid && !pix_stall)
        begin
            if (pending_pix.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel transfer, expected none, actual x %0d y %0d",
                         $time, pix.pixel_x, pix.pixel_y);
            end
            else
            begin
                want_pix = pending_pix.pop_front();
                report_field("pixel_x", want_pix.pixel_x, pix.pixel_x);
                report_field("pixel_y", want_pix.pixel_y, pix.pixel_y);
                report_field("pixel_valid", want_pix.pixel_valid, pix.pixel_valid);
                report_field("last_pixel", want_pix.last_pixel, pix.last_pixel);
                results_seen++;
                if (pix.pixel_valid)
                    pixels_seen++;
                if (pix.pixel_valid && pix.last_pixel)
                    ends_seen++;
            end
        end
        if (stall_left > 0)
        begin
            pix_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(3, 0) == 0)
        begin
            stall_left = pick_gap();
            pix_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
        else
            pix_stall <= 1'b0;
    end

    // Command side: directed table, then random line sequences.
    initial
    begin
        int random_items;
        int next_drain;
        int kind;
        int span;
        int xs;
        int ys;
        int xe;
        int ye;
        int steps;
        int adx;
        int ady;

        // Idle steps and zero-length lines at both corners of the screen.
        add_row(MODE_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 1);
        add_row(MODE_LOAD, 0, 0, 0, 0, 1, 0, 0, 0, 1);
        add_row(MODE_STEP, 4095, 4095, 4095, 4095, 1, 0, 0, 0, 1);
        add_row(MODE_LOAD, 4095, 4095, 4095, 4095, 1, 0, 0, 0, 1);
        // Full-screen diagonals in both directions; a tie keeps x as major axis.
        add_row(MODE_LOAD, 0, 0, 4095, 4095, 1, 0, 0, 1, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LOAD, 4095, 4095, 0, 0, 1, 0, 0, 1, 0);
        add_row(MODE_LOAD, 0, 4095, 4095, 0, 1, 0, 4095, 1, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LOAD, 4095, 0, 0, 4095, 1, 0, 4095, 1, 0);
        // Steep line covering the full height.
        add_row(MODE_LOAD, 5, 0, 7, 4095, 1, 5, 0, 1, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // Reversed horizontal line run to its end and past it.
        add_row(MODE_LOAD, 3, 3, 0, 3, 1, 0, 3, 1, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 1);
        // Steep descending line, vertical line, shallow descending line.
        add_row(MODE_LOAD, 10, 20, 7, 12, 0, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LOAD, 100, 50, 100, 49, 1, 100, 49, 1, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LOAD, 0, 10, 5, 8, 0, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // A load that abandons the line in progress.
        add_row(MODE_LOAD, 4000, 100, 3990, 97, 0, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // Two-pixel line.
        add_row(MODE_LOAD, 7, 7, 8, 7, 1, 7, 7, 1, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 1, 8, 7, 1, 1);

        do
            @(posedge clk);
        while (!rst_n);

        foreach (drill_rows[i])
            send_cmd(drill_rows[i].cmd, drill_rows[i].typed, drill_rows[i].want);
        wait_drained();

        random_items = 0;
        next_drain = DRAIN_EVERY;
        while (random_items < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(7, 0) == 0);
            kind = $urandom_range(99, 0);
            xs = rand_coord();
            ys = rand_coord();
            if (kind < 70 || kind >= 98)
            begin
                // Complete line, mostly short, now and then long.
                span = (kind >= 98) ? 400 : (($urandom_range(3, 0) == 0) ? 200 : 20);
                xe = near_coord(xs, span);
                ye = near_coord(ys, span);
                adx = (xe > xs) ? xe - xs : xs - xe;
                ady = (ye > ys) ? ye - ys : ys - ye;
                steps = ((adx > ady) ? adx : ady) + $urandom_range(1, 0);
            end
            else if (kind < 80)
            begin
                // Line anywhere on the screen, cut short by the next load.
                xe = rand_coord();
                ye = rand_coord();
                steps = $urandom_range(15, 0);
            end
            else if (kind < 88)
            begin
                // Zero-length line followed by idle steps.
                xe = xs;
                ye = ys;
                steps = $urandom_range(2, 0);
            end
            else
                steps = 0;

            if (kind < 88 || kind >= 98)
            begin
                send_cmd(make_cmd(MODE_LOAD, xs, ys, xe, ye), 1'b0, '0);
                random_items++;
                repeat (steps)
                begin
                    send_random_step();
                    random_items++;
                end
            end
            else
            begin
                // Noise: stray steps that may find no line.
                repeat ($urandom_range(3, 1))
                    send_random_step();
            end

            if (random_items >= next_drain)
            begin
                wait_drained();
                next_drain += DRAIN_EVERY;
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_pix.size() != 0)
        begin
            errors++;
            $display("%0t: %0d pixels never arrived", $time, pending_pix.size());
        end

        $display("Sent %0d commands: %0d loads and %0d steps over all octants.",
                 loads_sent + steps_sent, loads_sent, steps_sent);
        $display("Checked %0d results: %0d drawn pixels, %0d line end points, %0d errors.",
                 results_seen, pixels_seen, ends_seen, errors);
        if (errors == 0)
            $display("line_rasterizer_all_octants_core_tb OK");
        else
            $display("line_rasterizer_all_octants_core_tb NOT OK");
        $finish;
    end

endmodule
